// ===== src/phv_pkg.sv =====
// Shared types, codes and constants of the pattern header validator.
package phv_pkg;

  // Header layout
  localparam int HEADER_BYTES       = 17;
  localparam int FRAME_PREFIX_BYTES = 4;
  localparam int FRAME_CRC_BYTES    = 2;
  localparam int IDX_W              = $clog2(HEADER_BYTES + 1);

  localparam logic [IDX_W-1:0] IDX_MAGIC_0   = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_MAGIC_1   = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_MAGIC_2   = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_MAGIC_3   = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_VERSION   = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_FRAMES_LO = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_FRAMES_HI = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_ROWS      = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_COLS      = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_GRAY      = IDX_W'(10);
  localparam logic [IDX_W-1:0] IDX_MASK_FIRST = IDX_W'(11);
  localparam logic [IDX_W-1:0] IDX_CRC_BYTE  = IDX_W'(HEADER_BYTES - 1);
  localparam logic [IDX_W-1:0] IDX_DONE      = IDX_W'(HEADER_BYTES);

  // Magic bytes
  localparam logic [7:0] MAGIC_0 = 8'h47;
  localparam logic [7:0] MAGIC_1 = 8'h36;
  localparam logic [7:0] MAGIC_2 = 8'h50;
  localparam logic [7:0] MAGIC_3 = 8'h54;

  // CRC-8, poly 0x2F, init and final xor 0xFF
  localparam logic [7:0] CRC_POLY = 8'h2F;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_XOR  = 8'hFF;

  // Grayscale codes
  localparam logic [7:0] GRAY_TWO_LEVEL     = 8'd1;
  localparam logic [7:0] GRAY_SIXTEEN_LEVEL = 8'd2;

  // Verdict codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_HDR_BAD = 2'd1;
  localparam logic [1:0] STATUS_GEO_BAD = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_VERSION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PANELS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TWO      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIXTEEN  = 3'd5;

  // Shift-add multiplier geometry
  localparam int MUL_W   = 10;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int PANEL_W = 16;
  localparam int MASK_W  = 6;
  localparam int FRAME_BYTES_W = 21;

  // Per-byte request to the bit-serial byte unit
  typedef struct packed {
    logic go;
    logic crc_restart;
    logic crc_en;
    logic mask_clear;
    logic mask_en;
  } byte_ctl_t;

endpackage

// ===== src/phv_byte_unit.sv =====
// Bit-serial CRC-8 and panel-mask popcount, one bit of the header byte per cycle.
module phv_byte_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  phv_pkg::byte_ctl_t         ctl,
  input  logic [7:0]                 data,
  output logic [7:0]                 crc,
  output logic [phv_pkg::MASK_W-1:0] mask_ones,
  output logic                       busy,
  output logic                       done
);
  import phv_pkg::*;

  logic [2:0] bit_cnt;
  logic [7:0] shift;
  logic       crc_en_q;
  logic       mask_en_q;
  logic [7:0] crc_base;

  assign crc_base = ctl.crc_restart ? CRC_INIT : crc;

  // Load on a new byte, then shift out its bits one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      crc       <= CRC_INIT;
      mask_ones <= '0;
      bit_cnt   <= '0;
    end else begin
      done <= !ctl.go && busy && (bit_cnt == 3'd7);
      if (ctl.go) begin
        busy      <= 1'b1;
        bit_cnt   <= '0;
        crc_en_q  <= ctl.crc_en;
        mask_en_q <= ctl.mask_en;
        shift     <= data;
        crc       <= ctl.crc_en ? (crc_base ^ data) : crc_base;
        if (ctl.mask_clear) begin
          mask_ones <= '0;
        end
      end else if (busy) begin
        if (crc_en_q) begin
          crc <= crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
        end
        if (mask_en_q) begin
          mask_ones <= mask_ones + MASK_W'(shift[0]);
        end
        shift   <= {1'b0, shift[7:1]};
        bit_cnt <= bit_cnt + 3'd1;
        if (bit_cnt == 3'd7) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // A new byte never arrives while the unit is shifting
  assert property (@(posedge clk) disable iff (rst) ctl.go |-> !busy)
    else $error("byte unit restarted while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy && $past(busy))
    else $error("byte unit done without a shift pass");
  assert property (@(posedge clk) disable iff (rst) ctl.go |=> busy)
    else $error("byte unit did not start");

endmodule

// ===== src/phv_shift_mul.sv =====
// Iterative shift-add multiplier, one multiplier bit per cycle.
module phv_shift_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [phv_pkg::MUL_W-1:0]  a,
  input  logic [phv_pkg::MUL_W-1:0]  b,
  output logic [phv_pkg::PROD_W-1:0] product,
  output logic                       busy,
  output logic                       done
);
  import phv_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic [PROD_W-1:0] ma;
  logic [MUL_W-1:0]  mb;
  logic [CNT_W-1:0]  cnt;

  // Add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !go && busy && (cnt == CNT_W'(MUL_W - 1));
      if (go) begin
        busy    <= 1'b1;
        cnt     <= '0;
        ma      <= PROD_W'(a);
        mb      <= b;
        product <= '0;
      end else if (busy) begin
        if (mb[0]) begin
          product <= product + ma;
        end
        ma  <= {ma[PROD_W-2:0], 1'b0};
        mb  <= {1'b0, mb[MUL_W-1:1]};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) go |-> !busy)
    else $error("multiplier restarted while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy && $past(busy))
    else $error("multiplier done without a pass");
  assert property (@(posedge clk) disable iff (rst) go |=> busy)
    else $error("multiplier did not start");

endmodule

// ===== src/pattern_header_validator_top.sv =====
// Pattern header validator: byte sequencer, field capture, checks and verdict register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | input     | in_valid / in_ready    | start_of_header, header_byte
//  out     | output    | out_valid / out_ready  | status, num_frames .. frame_bytes
//  cfg     | input     | cfg_we (no wait)       | cfg_index, cfg_data
//
// Each header byte is accepted, then shifted through the bit-serial CRC/popcount unit.
// A byte arriving after the verdict without a start mark is accepted and dropped.
// The last header byte adds two passes of the shared shift-add multiplier
// (a load, then one shift per multiplier bit; rows*cols, then panels*block) and a load
// of the verdict register.
// The verdict waits while out_ready is low and the previous verdict is still held.
// rst is synchronous; after it the first byte counts as header byte 0.
module pattern_header_validator_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               start_of_header,
  input  logic [7:0]                         header_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [15:0]                        num_frames,
  output logic [7:0]                         panel_rows,
  output logic [7:0]                         panel_cols,
  output logic [1:0]                         gray_code,
  output logic [9:0]                         panel_block_bytes,
  output logic [9:0]                         panel_total,
  output logic [phv_pkg::FRAME_BYTES_W-1:0]  frame_bytes,
  input  logic                               cfg_we,
  input  logic [phv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [phv_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import phv_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BITS  = 3'd1;
  localparam logic [2:0] S_MUL_P = 3'd2;
  localparam logic [2:0] S_MUL_F = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]       state;
  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] cur_idx;
  logic [7:0]       last_byte;
  logic             early_fail;
  logic [15:0]      frames_held;
  logic [7:0]       rows_held;
  logic [7:0]       cols_held;
  logic [7:0]       gray_held;
  logic [PANEL_W-1:0] panels;

  logic [3:0] format_version;
  logic [7:0] expected_rows;
  logic [7:0] expected_cols;
  logic [9:0] max_panels;
  logic [9:0] block_bytes_two_level;
  logic [9:0] block_bytes_sixteen_level;

  logic [IDX_W-1:0]  idx_eff;
  logic              take;
  logic              fail_now;
  byte_ctl_t         bctl;
  logic [7:0]        crc;
  logic [MASK_W-1:0] mask_ones;
  logic              byte_busy;
  logic              byte_done;
  logic              mul_go;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] product;
  logic              mul_busy;
  logic              mul_done;
  logic [9:0]        block_sel;
  logic              hdr_bad;
  logic              geo_bad;
  logic              out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      format_version            <= 4'd1;
      expected_rows             <= 8'd2;
      expected_cols             <= 8'd10;
      max_panels                <= 10'd40;
      block_bytes_two_level     <= 10'd53;
      block_bytes_sixteen_level <= 10'd203;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT_VERSION: format_version            <= cfg_data[3:0];
        REG_EXPECTED_ROWS:  expected_rows             <= cfg_data[7:0];
        REG_EXPECTED_COLS:  expected_cols             <= cfg_data[7:0];
        REG_MAX_PANELS:     max_panels                <= cfg_data;
        REG_BLOCK_TWO:      block_bytes_two_level     <= cfg_data;
        REG_BLOCK_SIXTEEN:  block_bytes_sixteen_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the incoming request
  assign in_ready = (state == S_IDLE);
  assign idx_eff  = start_of_header ? '0 : byte_index;
  assign take     = in_valid && in_ready && (idx_eff < IDX_DONE);

  always_comb begin
    case (idx_eff)
      IDX_MAGIC_0: fail_now = (header_byte != MAGIC_0);
      IDX_MAGIC_1: fail_now = (header_byte != MAGIC_1);
      IDX_MAGIC_2: fail_now = (header_byte != MAGIC_2);
      IDX_MAGIC_3: fail_now = (header_byte != MAGIC_3);
      IDX_VERSION: fail_now = (header_byte[7:4] != format_version);
      default:     fail_now = 1'b0;
    endcase
  end

  always_comb begin
    bctl.go          = take;
    bctl.crc_restart = start_of_header;
    bctl.crc_en      = (idx_eff < IDX_CRC_BYTE);
    bctl.mask_clear  = (idx_eff == IDX_MASK_FIRST);
    bctl.mask_en     = (idx_eff >= IDX_MASK_FIRST);
  end

  phv_byte_unit u_byte (
    .clk       (clk),
    .rst       (rst),
    .ctl       (bctl),
    .data      (header_byte),
    .crc       (crc),
    .mask_ones (mask_ones),
    .busy      (byte_busy),
    .done      (byte_done)
  );

  // Shared multiplier: rows*cols first, then panels*block
  assign block_sel = (gray_held == GRAY_TWO_LEVEL) ? block_bytes_two_level
                                                   : block_bytes_sixteen_level;
  assign mul_go = (state == S_BITS && byte_done && cur_idx == IDX_CRC_BYTE) ||
                  (state == S_MUL_P && mul_done);
  assign mul_a  = (state == S_BITS) ? MUL_W'(rows_held) : product[MUL_W-1:0];
  assign mul_b  = (state == S_BITS) ? MUL_W'(cols_held) : block_sel;

  phv_shift_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .go      (mul_go),
    .a       (mul_a),
    .b       (mul_b),
    .product (product),
    .busy    (mul_busy),
    .done    (mul_done)
  );

  // Verdict checks, header rules ahead of geometry rules
  assign hdr_bad = early_fail || ((crc ^ CRC_XOR) != last_byte) || (frames_held == 16'd0) ||
                   !((gray_held == GRAY_TWO_LEVEL) || (gray_held == GRAY_SIXTEEN_LEVEL));
  assign geo_bad = (panels == '0) || (panels > PANEL_W'(max_panels)) ||
                   (PANEL_W'(mask_ones) > panels) ||
                   (rows_held != expected_rows) || (cols_held != expected_cols);
  assign out_free = !out_valid || out_ready;

  // Sequencer and field capture
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      byte_index  <= '0;
      early_fail  <= 1'b0;
      frames_held <= '0;
      rows_held   <= '0;
      cols_held   <= '0;
      gray_held   <= '0;
      cur_idx     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            state      <= S_BITS;
            cur_idx    <= idx_eff;
            last_byte  <= header_byte;
            byte_index <= idx_eff + IDX_W'(1);
            early_fail <= (early_fail && !start_of_header) || fail_now;
            case (idx_eff)
              IDX_FRAMES_LO: frames_held <= {8'd0, header_byte};
              IDX_FRAMES_HI: frames_held <= {header_byte, frames_held[7:0]};
              IDX_ROWS:      rows_held   <= header_byte;
              IDX_COLS:      cols_held   <= header_byte;
              IDX_GRAY:      gray_held   <= header_byte;
              default: ;
            endcase
          end
        end
        S_BITS: begin
          if (byte_done) begin
            state <= (cur_idx == IDX_CRC_BYTE) ? S_MUL_P : S_IDLE;
          end
        end
        S_MUL_P: begin
          if (mul_done) begin
            panels <= product[PANEL_W-1:0];
            state  <= S_MUL_F;
          end
        end
        S_MUL_F: begin
          if (mul_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Verdict register: hold until taken, zero the data fields on failure
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
      if (hdr_bad || geo_bad) begin
        status            <= hdr_bad ? STATUS_HDR_BAD : STATUS_GEO_BAD;
        num_frames        <= '0;
        panel_rows        <= '0;
        panel_cols        <= '0;
        gray_code         <= '0;
        panel_block_bytes <= '0;
        panel_total       <= '0;
        frame_bytes       <= '0;
      end else begin
        status            <= STATUS_OK;
        num_frames        <= frames_held;
        panel_rows        <= rows_held;
        panel_cols        <= cols_held;
        gray_code         <= gray_held[1:0];
        panel_block_bytes <= block_sel;
        panel_total       <= panels[9:0];
        frame_bytes       <= FRAME_BYTES_W'(product) +
                             FRAME_BYTES_W'(FRAME_PREFIX_BYTES + FRAME_CRC_BYTES);
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      out_valid && status == STATUS_OK |->
      (16'(panel_rows) * 16'(panel_cols)) == {6'd0, panel_total})
    else $error("panel total disagrees with geometry");
  assert property (@(posedge clk) disable iff (rst)
      out_valid && status != STATUS_OK |-> frame_bytes == '0 && num_frames == '0)
    else $error("data fields not cleared on failure");
  assert property (@(posedge clk) disable iff (rst) byte_index <= IDX_DONE)
    else $error("byte counter ran past the header");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !byte_busy && !mul_busy)
    else $error("ready while a shared unit is working");

endmodule

// ===== tb/phv_checker.sv =====
// Verdict scoreboard for the pattern header validator: predicts every verdict and compares it.
module phv_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               start_of_header,
  input  logic [7:0]                         header_byte,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [1:0]                         status,
  input  logic [15:0]                        num_frames,
  input  logic [7:0]                         panel_rows,
  input  logic [7:0]                         panel_cols,
  input  logic [1:0]                         gray_code,
  input  logic [9:0]                         panel_block_bytes,
  input  logic [9:0]                         panel_total,
  input  logic [phv_pkg::FRAME_BYTES_W-1:0]  frame_bytes,
  input  logic                               cfg_we,
  input  logic [phv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [phv_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import phv_pkg::*;

  typedef struct packed {
    logic [1:0]               status;
    logic [15:0]              frames;
    logic [7:0]               rows;
    logic [7:0]               cols;
    logic [1:0]               gray;
    logic [9:0]               block;
    logic [9:0]               total;
    logic [FRAME_BYTES_W-1:0] fbytes;
  } verdict_t;

  verdict_t expected_verdicts[$];
  int       fails = 0;
  int       waiting = 0;
  int       verdicts_seen = 0;

  // Arena settings as last written
  logic [3:0] fmt_version;
  logic [7:0] arena_rows;
  logic [7:0] arena_cols;
  logic [9:0] panel_limit;
  logic [9:0] blk_two;
  logic [9:0] blk_sixteen;

  // Header parse state
  logic [IDX_W-1:0] pos;
  logic [7:0]       crc;
  logic             early_bad;
  logic [15:0]      frames_seen;
  logic [7:0]       rows_seen;
  logic [7:0]       cols_seen;
  logic [7:0]       gray_seen;
  logic [5:0]       mask_ones;

  assign fail_count = fails;
  assign pending    = waiting;

  // Count a mismatch and print it
  task automatic flag(input string msg);
    fails++;
    $display("MISMATCH %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want)
      flag($sformatf("verdict %0d %s: expected %0d, got %0d", verdicts_seen, name, want, got));
  endtask

  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // Advance the parse by one header byte; queue a verdict after the CRC byte
  task automatic take_byte(input logic sos, input logic [7:0] b);
    verdict_t         v;
    int unsigned      panels;
    logic [9:0]       blk;
    logic [IDX_W-1:0] at;
    if (sos) begin
      pos = '0;
      crc = CRC_INIT;
      early_bad = 1'b0;
    end
    // drop bytes after the verdict until the next start mark
    if (pos >= IDX_DONE) return;
    at = pos;
    case (at)
      IDX_MAGIC_0:   if (b != MAGIC_0) early_bad = 1'b1;
      IDX_MAGIC_1:   if (b != MAGIC_1) early_bad = 1'b1;
      IDX_MAGIC_2:   if (b != MAGIC_2) early_bad = 1'b1;
      IDX_MAGIC_3:   if (b != MAGIC_3) early_bad = 1'b1;
      IDX_VERSION:   if (b[7:4] != fmt_version) early_bad = 1'b1;
      IDX_FRAMES_LO: frames_seen = {8'h00, b};
      IDX_FRAMES_HI: frames_seen[15:8] = b;
      IDX_ROWS:      rows_seen = b;
      IDX_COLS:      cols_seen = b;
      IDX_GRAY:      gray_seen = b;
      default: ;
    endcase
    // mask popcount runs through the CRC byte
    if (at == IDX_MASK_FIRST) mask_ones = '0;
    if (at >= IDX_MASK_FIRST) mask_ones = mask_ones + 6'($countones(b));
    if (at != IDX_CRC_BYTE) crc = crc8_next(crc, b);
    pos = at + 1'b1;
    if (at != IDX_CRC_BYTE) return;

    // header rules first, then grid rules; first failure wins
    panels = rows_seen * cols_seen;
    v = '0;
    if (early_bad || (crc ^ CRC_XOR) != b)                        v.status = STATUS_HDR_BAD;
    else if (frames_seen == 16'd0)                                v.status = STATUS_HDR_BAD;
    else if (gray_seen != GRAY_TWO_LEVEL && gray_seen != GRAY_SIXTEEN_LEVEL)
                                                                  v.status = STATUS_HDR_BAD;
    else if (panels == 0 || panels > panel_limit)                 v.status = STATUS_GEO_BAD;
    else if (mask_ones > panels)                                  v.status = STATUS_GEO_BAD;
    else if (rows_seen != arena_rows || cols_seen != arena_cols)  v.status = STATUS_GEO_BAD;
    else                                                          v.status = STATUS_OK;
    if (v.status == STATUS_OK) begin
      blk      = (gray_seen == GRAY_TWO_LEVEL) ? blk_two : blk_sixteen;
      v.frames = frames_seen;
      v.rows   = rows_seen;
      v.cols   = cols_seen;
      v.gray   = gray_seen[1:0];
      v.block  = blk;
      v.total  = panels[9:0];
      v.fbytes = FRAME_BYTES_W'(FRAME_PREFIX_BYTES + panels * blk + FRAME_CRC_BYTES);
    end
    expected_verdicts.push_back(v);
  endtask

  always @(posedge clk) begin : watch
    verdict_t got;
    verdict_t want;
    if (rst) begin
      fmt_version = 4'd1;
      arena_rows  = 8'd2;
      arena_cols  = 8'd10;
      panel_limit = 10'd40;
      blk_two     = 10'd53;
      blk_sixteen = 10'd203;
      pos         = '0;
      crc         = CRC_INIT;
      early_bad   = 1'b0;
      frames_seen = '0;
      rows_seen   = '0;
      cols_seen   = '0;
      gray_seen   = '0;
      mask_ones   = '0;
      expected_verdicts.delete();
    end else begin
      if (in_valid && in_ready) take_byte(start_of_header, header_byte);
      // mirror register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_FORMAT_VERSION: fmt_version = cfg_data[3:0];
          REG_EXPECTED_ROWS:  arena_rows  = cfg_data[7:0];
          REG_EXPECTED_COLS:  arena_cols  = cfg_data[7:0];
          REG_MAX_PANELS:     panel_limit = cfg_data;
          REG_BLOCK_TWO:      blk_two     = cfg_data;
          REG_BLOCK_SIXTEEN:  blk_sixteen = cfg_data;
          default: ;
        endcase
      end
      // compare each delivered verdict with the oldest prediction
      if (out_valid && out_ready) begin
        got = {status, num_frames, panel_rows, panel_cols, gray_code,
               panel_block_bytes, panel_total, frame_bytes};
        if (expected_verdicts.size() == 0) begin
          flag($sformatf("verdict %0d arrived with none predicted", verdicts_seen));
        end else begin
          want = expected_verdicts.pop_front();
          check_field("status", want.status, got.status);
          check_field("num_frames", want.frames, got.frames);
          check_field("panel_rows", want.rows, got.rows);
          check_field("panel_cols", want.cols, got.cols);
          check_field("gray_code", want.gray, got.gray);
          check_field("panel_block_bytes", want.block, got.block);
          check_field("panel_total", want.total, got.total);
          check_field("frame_bytes", want.fbytes, got.fbytes);
        end
        verdicts_seen++;
      end
    end
    waiting = expected_verdicts.size();
  end

endmodule

// ===== tb/pattern_header_validator_top_tb.sv =====
// Testbench top for the pattern header validator: clock, reset, header stimulus and verdict.
module pattern_header_validator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phv_pkg::*;

  localparam int ITEMS         = 1300;
  localparam int PHASE_ITEMS   = 160;
  localparam int SETTLE_CYCLES = 60;

  typedef enum int {
    HDR_GOOD,
    HDR_BAD_MAGIC,
    HDR_BAD_VERSION,
    HDR_BAD_CRC,
    HDR_NO_FRAMES,
    HDR_BAD_GRAY,
    HDR_BAD_GRID,
    HDR_DENSE_MASK,
    HDR_NOISE
  } header_kind_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     start_of_header = 1'b0;
  logic [7:0]               header_byte = 8'h00;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic [15:0]              num_frames;
  logic [7:0]               panel_rows;
  logic [7:0]               panel_cols;
  logic [1:0]               gray_code;
  logic [9:0]               panel_block_bytes;
  logic [9:0]               panel_total;
  logic [FRAME_BYTES_W-1:0] frame_bytes;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_FORMAT_VERSION;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  int  fail_count;
  int  pending;
  int  sent = 0;
  bit  steady = 1'b0;

  // Arena the generated good headers are built for
  logic [3:0] cur_version = 4'd1;
  logic [7:0] cur_rows    = 8'd2;
  logic [7:0] cur_cols    = 8'd10;

  logic [7:0] hdr [HEADER_BYTES];

  pattern_header_validator_top u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .start_of_header   (start_of_header),
    .header_byte       (header_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .num_frames        (num_frames),
    .panel_rows        (panel_rows),
    .panel_cols        (panel_cols),
    .gray_code         (gray_code),
    .panel_block_bytes (panel_block_bytes),
    .panel_total       (panel_total),
    .frame_bytes       (frame_bytes),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  phv_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .start_of_header   (start_of_header),
    .header_byte       (header_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .num_frames        (num_frames),
    .panel_rows        (panel_rows),
    .panel_cols        (panel_cols),
    .gray_code         (gray_code),
    .panel_block_bytes (panel_block_bytes),
    .panel_total       (panel_total),
    .frame_bytes       (frame_bytes),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the verdict port now and then, except in the steady stretch
  always @(negedge clk) begin
    out_ready = steady || ($urandom_range(0, 99) >= 15);
  end

  // Hard stop if the run hangs or a verdict never shows up
  initial begin : watchdog
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic apply_config(input logic [3:0] ver, input logic [7:0] r, input logic [7:0] c,
                              input logic [9:0] lim, input logic [9:0] b2,
                              input logic [9:0] b16);
    write_reg(REG_FORMAT_VERSION, CFG_DATA_W'(ver));
    write_reg(REG_EXPECTED_ROWS, CFG_DATA_W'(r));
    write_reg(REG_EXPECTED_COLS, CFG_DATA_W'(c));
    write_reg(REG_MAX_PANELS, lim);
    write_reg(REG_BLOCK_TWO, b2);
    write_reg(REG_BLOCK_SIXTEEN, b16);
    cur_version = ver;
    cur_rows    = r;
    cur_cols    = c;
  endtask

  // Drop valid, drain all verdicts, then let the byte engine go quiet
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Offer one byte, with an occasional gap first, and hold it until taken
  task automatic send_byte(input logic sos, input logic [7:0] b);
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 15) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid        = 1'b1;
    start_of_header = sos;
    header_byte     = b;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_prefix(input int n, input logic marked);
    for (int i = 0; i < n; i++) send_byte(marked && i == 0, hdr[i]);
  endtask

  task automatic seal_header();
    logic [7:0] c;
    c = CRC_INIT;
    for (int i = 0; i < HEADER_BYTES - 1; i++) begin
      c = c ^ hdr[i];
      for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    hdr[HEADER_BYTES-1] = c ^ CRC_XOR;
  endtask

  // Fill hdr with a well-formed header for the current arena, then break it as asked
  task automatic build_header(input header_kind_t kind);
    logic [15:0] frames;
    int          r;
    int          at;
    hdr[0] = MAGIC_0;
    hdr[1] = MAGIC_1;
    hdr[2] = MAGIC_2;
    hdr[3] = MAGIC_3;
    hdr[4] = {cur_version, 4'($urandom)};
    hdr[5] = 8'($urandom);
    r = $urandom_range(0, 9);
    frames = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0001 : 16'($urandom);
    if (frames == 16'd0) frames = 16'h8000;
    {hdr[7], hdr[6]} = frames;
    hdr[8]  = cur_rows;
    hdr[9]  = cur_cols;
    hdr[10] = ($urandom_range(0, 1) != 0) ? GRAY_TWO_LEVEL : GRAY_SIXTEEN_LEVEL;
    // keep the panel mask sparse so most good headers pass the popcount rule
    for (int i = IDX_MASK_FIRST; i < HEADER_BYTES - 1; i++)
      hdr[i] = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom & $urandom & $urandom);
    case (kind)
      HDR_BAD_MAGIC: begin
        at = $urandom_range(0, 3);
        hdr[at] = hdr[at] ^ 8'(1 << $urandom_range(0, 7));
      end
      HDR_BAD_VERSION: hdr[4][7:4] = cur_version + 4'($urandom_range(1, 15));
      HDR_NO_FRAMES: begin
        hdr[6] = 8'h00;
        hdr[7] = 8'h00;
      end
      HDR_BAD_GRAY: begin
        r = $urandom_range(0, 2);
        if (r == 0) hdr[10] = 8'h00;
        else if (r == 1) hdr[10] = 8'hFF;
        else begin
          do hdr[10] = 8'($urandom);
          while (hdr[10] == GRAY_TWO_LEVEL || hdr[10] == GRAY_SIXTEEN_LEVEL);
        end
      end
      HDR_BAD_GRID: begin
        r = $urandom_range(0, 3);
        if (r == 0) begin
          hdr[8] = 8'hFF;
          hdr[9] = 8'hFF;
        end else if (r == 1) hdr[8] = 8'($urandom);
        else if (r == 2) hdr[9] = 8'($urandom);
        else hdr[8] = 8'h00;
      end
      HDR_DENSE_MASK: begin
        for (int i = IDX_MASK_FIRST; i < HEADER_BYTES - 1; i++)
          hdr[i] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom);
      end
      HDR_NOISE: begin
        for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'($urandom);
      end
      default: ;
    endcase
    if (kind != HDR_NOISE) seal_header();
    if (kind == HDR_BAD_CRC) hdr[HEADER_BYTES-1] = hdr[HEADER_BYTES-1] ^ 8'($urandom_range(1, 255));
  endtask

  // Pick arena settings per phase: extremes first, then random
  task automatic program_phase(input int phase);
    int r;
    int c;
    int lim;
    case (phase)
      1: apply_config(4'd0, 8'd1, 8'd1, 10'd1, 10'd0, 10'd1);
      2: apply_config(4'd15, 8'd31, 8'd33, 10'd1023, 10'd1023, 10'd1023);
      3: apply_config(4'd7, 8'd255, 8'd0, 10'd0, 10'($urandom), 10'd0);
      4: apply_config(4'($urandom), 8'd0, 8'd255, 10'd1023, 10'($urandom), 10'($urandom));
      5: apply_config(4'($urandom), 8'd255, 8'd4, 10'd1023, 10'($urandom), 10'($urandom));
      default: begin
        r = $urandom_range(1, 32);
        c = $urandom_range(1, 31);
        lim = ($urandom_range(0, 99) < 80) ? r * c + $urandom_range(0, 31) : $urandom_range(0, 1023);
        if (lim > 1023) lim = 1023;
        apply_config(4'($urandom), 8'(r), 8'(c), 10'(lim), 10'($urandom), 10'($urandom));
      end
    endcase
  endtask

  // One random request sequence: mostly well-formed headers, some broken, some noise
  task automatic random_header();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      build_header(HDR_GOOD);
      send_prefix(HEADER_BYTES, 1'b1);
    end else if (r < 85) begin
      build_header(header_kind_t'($urandom_range(HDR_BAD_MAGIC, HDR_DENSE_MASK)));
      send_prefix(HEADER_BYTES, 1'b1);
    end else if (r < 90) begin
      // noise with scattered start marks
      build_header(HDR_NOISE);
      for (int i = 0; i < HEADER_BYTES; i++)
        send_byte(i == 0 ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0), hdr[i]);
    end else if (r < 95) begin
      // cut short; the next start mark restarts the count
      build_header(HDR_GOOD);
      n = $urandom_range(1, HEADER_BYTES - 1);
      send_prefix(n, 1'b1);
    end else if (r < 98) begin
      // stray bytes with no start mark
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_byte(1'b0, 8'($urandom));
    end else begin
      // whole header without a start mark
      build_header(HDR_GOOD);
      for (int i = 0; i < HEADER_BYTES; i++) send_byte(1'b0, hdr[i]);
    end
  endtask

  initial begin : stimulus
    int phase;
    int phase_end;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // first byte after reset counts as byte zero without a mark
    build_header(HDR_GOOD);
    send_prefix(HEADER_BYTES, 1'b0);
    // bytes after a verdict are dropped
    send_byte(1'b0, MAGIC_0);
    send_byte(1'b0, 8'hFF);
    // start mark in the middle of a header restarts it
    build_header(HDR_GOOD);
    send_prefix(5, 1'b1);
    build_header(HDR_GOOD);
    hdr[6]  = 8'hFF;
    hdr[7]  = 8'hFF;
    hdr[10] = GRAY_SIXTEEN_LEVEL;
    seal_header();
    send_prefix(HEADER_BYTES, 1'b1);
    build_header(HDR_BAD_CRC);
    send_prefix(HEADER_BYTES, 1'b1);

    for (phase = 0; sent < ITEMS; phase++) begin
      if (phase > 0) begin
        settle();
        program_phase(phase);
      end
      steady = (phase == 2);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end && sent < ITEMS) random_header();
    end
    steady = 1'b0;

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/phv_pkg.sv
src/phv_byte_unit.sv
src/phv_shift_mul.sv
src/pattern_header_validator_top.sv
tb/phv_checker.sv
tb/pattern_header_validator_top_tb.sv
